// ===== rtl/rei_pkg.sv =====
// shared types, codes and the half-step quadrature table for the rotary encoder core
package rei_pkg;

    localparam int unsigned COUNT_W = 8;
    localparam int unsigned MS_W    = 8;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_CW   = 2'd1;
    localparam logic [1:0] DIR_CCW  = 2'd2;

    localparam logic [2:0] QS_START = 3'd0;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 8'sd127;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = -8'sd127;

    localparam logic [MS_W-1:0] MS_SAT         = 8'd255;
    localparam logic [MS_W-1:0] DEBOUNCE_RESET = 8'd30;

    // one input sample as it travels through the core
    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic switch_level;
        logic ms_tick;
        logic take_count;
    } t_sample;

    typedef struct packed {
        logic [1:0] dir;
        logic [2:0] next;
    } t_quad_entry;

    function automatic t_quad_entry quad_lookup(input logic [2:0] state, input logic [1:0] ab);
        t_quad_entry e;
        e.dir  = DIR_NONE;
        e.next = 3'd0;
        case ({state, ab})
            5'b000_00: e.next = 3'd3;
            5'b000_01: e.next = 3'd2;
            5'b000_10: e.next = 3'd1;
            5'b000_11: e.next = 3'd0;
            5'b001_00: begin
                e.next = 3'd3;
                e.dir  = DIR_CCW;
            end
            5'b001_01: e.next = 3'd0;
            5'b001_10: e.next = 3'd1;
            5'b001_11: e.next = 3'd0;
            5'b010_00: begin
                e.next = 3'd3;
                e.dir  = DIR_CW;
            end
            5'b010_01: e.next = 3'd2;
            5'b010_10: e.next = 3'd0;
            5'b010_11: e.next = 3'd0;
            5'b011_00: e.next = 3'd3;
            5'b011_01: e.next = 3'd5;
            5'b011_10: e.next = 3'd4;
            5'b011_11: e.next = 3'd0;
            5'b100_00: e.next = 3'd3;
            5'b100_01: e.next = 3'd3;
            5'b100_10: e.next = 3'd4;
            5'b100_11: begin
                e.next = 3'd0;
                e.dir  = DIR_CW;
            end
            5'b101_00: e.next = 3'd3;
            5'b101_01: e.next = 3'd5;
            5'b101_10: e.next = 3'd3;
            5'b101_11: begin
                e.next = 3'd0;
                e.dir  = DIR_CCW;
            end
            // unreachable states behave as the start state
            5'b110_00, 5'b111_00: e.next = 3'd3;
            5'b110_01, 5'b111_01: e.next = 3'd2;
            5'b110_10, 5'b111_10: e.next = 3'd1;
            default: e.next = 3'd0;
        endcase
        return e;
    endfunction

endpackage

// ===== rtl/rotary_encoder_interface_core.sv =====
// top level of the rotary encoder core: input register, decode and debounce, result register
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+---------------------------------------------
//   input    | i_in_valid   | o_in_stall   | i_pin_a i_pin_b i_switch_level i_ms_tick
//            |              |              | i_take_count
//   output   | o_out_valid  | i_out_stall  | o_count_taken o_step_dir o_press_event
//   config   | i_cfg_we     | none         | i_cfg_data (debounce_ms)
//
// one beat per cycle sustained while the output is not stalled; a beat is held in the input
// register and then moves to the result register, where its result is offered on the output.
// the table step, saturating count and debounce compare are combinational logic.
// synchronous active-low reset clears both valid bits and the decoder state.
// a stall on the output holds the result register and the input register and
// raises o_in_stall once the input register is full.
module rotary_encoder_interface_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_pin_a,
    input  logic                                  i_pin_b,
    input  logic                                  i_switch_level,
    input  logic                                  i_ms_tick,
    input  logic                                  i_take_count,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [rei_pkg::COUNT_W-1:0]    o_count_taken,
    output logic [1:0]                            o_step_dir,
    output logic                                  o_press_event,
    input  logic                                  i_cfg_we,
    input  logic [rei_pkg::MS_W-1:0]              i_cfg_data
);
    import rei_pkg::*;

    t_sample                    r_in;
    logic                       r_in_vld;
    logic                       r_out_vld;
    logic signed [COUNT_W-1:0]  r_count_taken;
    logic [1:0]                 r_step_dir;
    logic                       r_press;
    logic                       w_out_free;
    logic                       w_adv;
    logic                       w_in_acc;
    logic signed [COUNT_W-1:0]  w_count_taken;
    logic [1:0]                 w_step_dir;
    logic                       w_press;

    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_adv      = r_in_vld && w_out_free;
    assign w_in_acc   = i_in_valid && (!r_in_vld || w_adv);
    assign o_in_stall = r_in_vld && !w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in.pin_a        <= i_pin_a;
            r_in.pin_b        <= i_pin_b;
            r_in.switch_level <= i_switch_level;
            r_in.ms_tick      <= i_ms_tick;
            r_in.take_count   <= i_take_count;
        end
    end

    rei_quad u_quad (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_smp         (r_in),
        .o_step_dir    (w_step_dir),
        .o_count_taken (w_count_taken)
    );

    rei_debounce u_debounce (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_smp      (r_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_press    (w_press)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_count_taken <= w_count_taken;
            r_step_dir    <= w_step_dir;
            r_press       <= w_press;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_count_taken = r_count_taken;
    assign o_step_dir    = r_step_dir;
    assign o_press_event = r_press;

`ifndef SYNTHESIS
    // a held result must not be overwritten by the stage behind it
    a_no_adv_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_out_stall |-> !w_adv)
        else $error("stage advanced into a stalled result register");

    // count is only reported on a take beat
    a_taken_needs_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && !r_in.take_count |-> w_count_taken == '0)
        else $error("count reported without take");

    // press only reported for a low switch sample
    a_press_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_press |-> !r_in.switch_level)
        else $error("press raised on released switch");

    // saturation keeps the count inside +/-127
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_count_taken != 8'sh80)
        else $error("step count left its saturation range");
`endif

endmodule

// ===== rtl/rei_quad.sv =====
// half-step quadrature decoder with saturating step count and read-and-clear
module rei_quad (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_adv,
    input  rei_pkg::t_sample                      i_smp,
    output logic [1:0]                            o_step_dir,
    output logic signed [rei_pkg::COUNT_W-1:0]    o_count_taken
);
    import rei_pkg::*;

    logic [2:0]                 r_state;
    logic [2:0]                 n_state;
    logic signed [COUNT_W-1:0]  r_count;
    logic signed [COUNT_W-1:0]  n_count;
    logic signed [COUNT_W-1:0]  w_count_step;
    t_quad_entry                w_entry;

    always_comb begin
        w_entry      = quad_lookup(r_state, {i_smp.pin_a, i_smp.pin_b});
        n_state      = w_entry.next;
        w_count_step = r_count;
        if (w_entry.dir == DIR_CW && r_count != COUNT_MAX) begin
            w_count_step = r_count + 8'sd1;
        end else if (w_entry.dir == DIR_CCW && r_count != COUNT_MIN) begin
            w_count_step = r_count - 8'sd1;
        end
        // take returns the count including this beat's step
        n_count       = i_smp.take_count ? '0 : w_count_step;
        o_count_taken = i_smp.take_count ? w_count_step : '0;
        o_step_dir    = w_entry.dir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= QS_START;
            r_count <= '0;
        end else if (i_adv) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/rei_debounce.sv =====
// push switch debounce with ms elapsed counter and press detection
module rei_debounce (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  rei_pkg::t_sample              i_smp,
    input  logic                          i_cfg_we,
    input  logic [rei_pkg::MS_W-1:0]      i_cfg_data,
    output logic                          o_press
);
    import rei_pkg::*;

    logic [MS_W-1:0] r_debounce_ms;
    logic [MS_W-1:0] r_elapsed;
    logic [MS_W-1:0] n_elapsed;
    logic [MS_W-1:0] w_elapsed_tick;
    logic            r_last;
    logic            n_last;
    logic            w_change;

    always_comb begin
        w_elapsed_tick = r_elapsed;
        if (i_smp.ms_tick && r_elapsed != MS_SAT) begin
            w_elapsed_tick = r_elapsed + 8'd1;
        end
        w_change  = (i_smp.switch_level != r_last) && (w_elapsed_tick > r_debounce_ms);
        n_elapsed = w_change ? '0 : w_elapsed_tick;
        n_last    = w_change ? i_smp.switch_level : r_last;
        o_press   = w_change && !i_smp.switch_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RESET;
            r_elapsed     <= MS_SAT;
            r_last        <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_debounce_ms <= i_cfg_data;
            end
            if (i_adv) begin
                r_elapsed <= n_elapsed;
                r_last    <= n_last;
            end
        end
    end

endmodule

// ===== tb/rotary_encoder_interface_core_tb.sv =====
// self-checking testbench for the rotary encoder core: directed table, then random detent traffic
module rotary_encoder_interface_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rei_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_CYCLES  = 64;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned MAX_SHOWN    = 10;

    localparam int TAKE_NEVER  = 0;
    localparam int TAKE_SOME   = 1;
    localparam int TAKE_ALWAYS = 2;

    // half-step table: next state in [2:0], direction in [5:4], indexed by state and {a,b}
    localparam logic [0:7][0:3][5:0] HS_TABLE = {
        6'h03, 6'h02, 6'h01, 6'h00,
        6'h23, 6'h00, 6'h01, 6'h00,
        6'h13, 6'h02, 6'h00, 6'h00,
        6'h03, 6'h05, 6'h04, 6'h00,
        6'h03, 6'h03, 6'h04, 6'h10,
        6'h03, 6'h05, 6'h03, 6'h20,
        6'h03, 6'h02, 6'h01, 6'h00,
        6'h03, 6'h02, 6'h01, 6'h00
    };

    // {a,b} sequences of one full detent cycle starting from rest at 11
    localparam logic [0:3][1:0] CW_PATH  = {2'b01, 2'b00, 2'b10, 2'b11};
    localparam logic [0:3][1:0] CCW_PATH = {2'b10, 2'b00, 2'b01, 2'b11};

    typedef struct packed {
        logic signed [COUNT_W-1:0] count;
        logic [1:0]                dir;
        logic                      press;
    } t_result;

    typedef struct packed {
        t_sample s;
        logic    typed;
        t_result r;
    } t_stim;

    typedef struct packed {
        logic                      a;
        logic                      b;
        logic                      sw;
        logic                      tick;
        logic                      take;
        logic                      typed;
        logic signed [COUNT_W-1:0] cnt;
        logic [1:0]                dir;
        logic                      press;
    } t_row;

    localparam int N_DIRECTED = 22;
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{1, 1, 1, 0, 0, 1,  8'sd0, DIR_NONE, 0},   // at rest after reset
        '{0, 1, 1, 0, 0, 1,  8'sd0, DIR_NONE, 0},
        '{0, 0, 1, 0, 0, 1,  8'sd0, DIR_CW,   0},
        '{1, 0, 1, 0, 0, 1,  8'sd0, DIR_NONE, 0},
        '{1, 1, 1, 0, 1, 1,  8'sd2, DIR_CW,   0},   // take includes this beat's step
        '{1, 0, 1, 0, 0, 1,  8'sd0, DIR_NONE, 0},
        '{0, 0, 1, 0, 0, 1,  8'sd0, DIR_CCW,  0},
        '{0, 1, 1, 0, 0, 1,  8'sd0, DIR_NONE, 0},
        '{1, 1, 1, 0, 1, 1, -8'sd2, DIR_CCW,  0},
        '{1, 1, 1, 0, 1, 1,  8'sd0, DIR_NONE, 0},   // take of an empty count
        '{1, 1, 0, 1, 0, 1,  8'sd0, DIR_NONE, 1},   // elapsed starts saturated, first press passes
        '{1, 1, 1, 1, 0, 1,  8'sd0, DIR_NONE, 0},   // release bounce inside the window
        '{1, 1, 0, 1, 0, 1,  8'sd0, DIR_NONE, 0},
        '{0, 0, 0, 0, 0, 0,  8'sd0, DIR_NONE, 0},   // both channels jump at once
        '{1, 1, 0, 0, 0, 0,  8'sd0, DIR_NONE, 0},
        '{0, 1, 0, 0, 0, 0,  8'sd0, DIR_NONE, 0},   // start a turn, then back out
        '{1, 1, 0, 0, 0, 0,  8'sd0, DIR_NONE, 0},
        '{0, 1, 0, 0, 0, 0,  8'sd0, DIR_NONE, 0},
        '{0, 0, 0, 0, 0, 0,  8'sd0, DIR_NONE, 0},
        '{0, 1, 0, 0, 0, 0,  8'sd0, DIR_NONE, 0},   // reverse mid-detent
        '{1, 1, 1, 1, 1, 0,  8'sd0, DIR_NONE, 0},
        '{0, 0, 0, 0, 0, 0,  8'sd0, DIR_NONE, 0}
    };

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_in_valid     = 1'b0;
    logic                      o_in_stall;
    logic                      i_pin_a        = 1'b1;
    logic                      i_pin_b        = 1'b1;
    logic                      i_switch_level = 1'b1;
    logic                      i_ms_tick      = 1'b0;
    logic                      i_take_count   = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_stall    = 1'b0;
    logic signed [COUNT_W-1:0] o_count_taken;
    logic [1:0]                o_step_dir;
    logic                      o_press_event;
    logic                      i_cfg_we       = 1'b0;
    logic [MS_W-1:0]           i_cfg_data     = '0;

    // decoder model state
    logic [2:0]                dec_state    = QS_START;
    logic signed [COUNT_W-1:0] steps        = '0;
    logic                      sw_last      = 1'b1;
    logic [MS_W-1:0]           ms_since     = MS_SAT;
    logic [MS_W-1:0]           debounce_lim = DEBOUNCE_RESET;

    t_stim       stim_q[$];
    t_result     pending_results[$];
    int unsigned bad_beats   = 0;
    int unsigned cycle_count = 0;
    bit          tx_calm     = 1'b0;
    bit          rx_calm     = 1'b0;
    bit          rx_hold_req = 1'b0;
    logic        sw_level    = 1'b1;

    rotary_encoder_interface_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pin_a        (i_pin_a),
        .i_pin_b        (i_pin_b),
        .i_switch_level (i_switch_level),
        .i_ms_tick      (i_ms_tick),
        .i_take_count   (i_take_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_count_taken  (o_count_taken),
        .o_step_dir     (o_step_dir),
        .o_press_event  (o_press_event),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_result decode_sample(input t_sample s);
        t_result    r;
        logic [5:0] ent;
        r = '0;
        ent = HS_TABLE[dec_state][{s.pin_a, s.pin_b}];
        dec_state = ent[2:0];
        r.dir = ent[5:4];
        if (r.dir == DIR_CW && steps < COUNT_MAX)
            steps = steps + 8'sd1;
        else if (r.dir == DIR_CCW && steps > COUNT_MIN)
            steps = steps - 8'sd1;
        if (s.take_count) begin
            r.count = steps;
            steps = '0;
        end
        if (s.ms_tick && ms_since != MS_SAT)
            ms_since = ms_since + 8'd1;
        if (s.switch_level != sw_last && ms_since > debounce_lim) begin
            ms_since = '0;
            sw_last = s.switch_level;
            r.press = !s.switch_level;
        end
        return r;
    endfunction

    function automatic int unsigned pick_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic void queue_sample(input logic [1:0] ab, input int take_mode,
                                         input int unsigned tick_pct);
        t_stim st;
        st = '0;
        if ($urandom_range(0, 24) == 0)
            sw_level = !sw_level;
        st.s.pin_a = ab[1];
        st.s.pin_b = ab[0];
        // occasional chatter against the held level
        st.s.switch_level = ($urandom_range(0, 29) == 0) ? !sw_level : sw_level;
        st.s.ms_tick = ($urandom_range(0, 99) < tick_pct);
        st.s.take_count = (take_mode == TAKE_ALWAYS) ||
                          (take_mode == TAKE_SOME && $urandom_range(0, 15) == 0);
        stim_q.push_back(st);
    endfunction

    function automatic void queue_turns(input bit cw, input int unsigned turns,
                                        input int take_mode, input int unsigned tick_pct,
                                        input bit bouncy);
        logic [1:0] ab;
        logic [1:0] prev;
        for (int t = 0; t < turns; t++) begin
            for (int k = 0; k < 4; k++) begin
                ab   = cw ? CW_PATH[k] : CCW_PATH[k];
                prev = cw ? CW_PATH[(k + 3) % 4] : CCW_PATH[(k + 3) % 4];
                if (bouncy && $urandom_range(0, 11) == 0) begin
                    queue_sample(ab, take_mode, tick_pct);
                    queue_sample(prev, take_mode, tick_pct);
                end
                queue_sample(ab, take_mode, tick_pct);
            end
        end
    endfunction

    function automatic void queue_random(input int unsigned n, input int unsigned tick_pct);
        int unsigned stop;
        stop = stim_q.size() + n;
        while (stim_q.size() < stop) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6))
                    queue_sample(2'($urandom_range(0, 3)), TAKE_SOME, tick_pct);
            end else if ($urandom_range(0, 39) == 0) begin
                queue_turns(1'($urandom_range(0, 1)), $urandom_range(20, 50), TAKE_NEVER,
                            tick_pct, 1'b0);
            end else begin
                queue_turns(1'($urandom_range(0, 1)), $urandom_range(1, 6), TAKE_SOME,
                            tick_pct, 1'b1);
            end
        end
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic drive_beat(input t_stim st);
        int unsigned gap;
        t_result     want;
        gap = pick_wait(tx_calm);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_pin_a        <= st.s.pin_a;
        i_pin_b        <= st.s.pin_b;
        i_switch_level <= st.s.switch_level;
        i_ms_tick      <= st.s.ms_tick;
        i_take_count   <= st.s.take_count;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        want = decode_sample(st.s);
        if (st.typed)
            want = st.r;
        pending_results.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic run_phase();
        while (stim_q.size() != 0)
            drive_beat(stim_q.pop_front());
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_debounce(input logic [MS_W-1:0] value);
        while (pending_results.size() != 0)
            @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        debounce_lim = value;
    endtask

    initial begin : rx_side
        int unsigned hold;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold = HOLD_CYCLES;
            end else begin
                hold = pick_wait(rx_calm);
            end
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
                bad_beats++;
                if (bad_beats <= MAX_SHOWN)
                    $display("unexpected result beat: count %0d dir %0d press %0b",
                             o_count_taken, o_step_dir, o_press_event);
            end else begin
                want = pending_results.pop_front();
                if (o_count_taken !== want.count || o_step_dir !== want.dir ||
                    o_press_event !== want.press) begin
                    bad_beats++;
                    if (bad_beats <= MAX_SHOWN)
                        $display("mismatch: count %0d/%0d dir %0d/%0d press %0b/%0b (exp/act)",
                                 want.count, o_count_taken, want.dir, o_step_dir,
                                 want.press, o_press_event);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : main_seq
        t_stim st;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            st = '0;
            st.s.pin_a        = DIRECTED[k].a;
            st.s.pin_b        = DIRECTED[k].b;
            st.s.switch_level = DIRECTED[k].sw;
            st.s.ms_tick      = DIRECTED[k].tick;
            st.s.take_count   = DIRECTED[k].take;
            st.typed          = DIRECTED[k].typed;
            st.r.count        = DIRECTED[k].cnt;
            st.r.dir          = DIRECTED[k].dir;
            st.r.press        = DIRECTED[k].press;
            stim_q.push_back(st);
        end
        // reset debounce value still in effect
        queue_random(120, 60);
        run_phase();

        // drive the count into both limits, clearing it first
        write_debounce(8'd0);
        queue_sample(2'b11, TAKE_ALWAYS, 50);
        queue_turns(1'b1, 66, TAKE_NEVER, 50, 1'b0);
        queue_sample(2'b11, TAKE_ALWAYS, 50);
        queue_turns(1'b0, 66, TAKE_NEVER, 50, 1'b0);
        queue_sample(2'b11, TAKE_ALWAYS, 50);
        queue_random(50, 50);
        run_phase();

        // long output hold-off while the input keeps offering beats
        write_debounce(8'd254);
        rx_hold_req = 1'b1;
        queue_random(160, 95);
        run_phase();

        // switch can never change at this setting
        write_debounce(8'd255);
        queue_random(80, 90);
        run_phase();

        repeat (3) begin
            write_debounce(8'($urandom_range(1, 12)));
            queue_random(100, $urandom_range(20, 80));
            run_phase();
        end

        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (bad_beats == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
